### rtl/csc_pkg.sv
package csc_pkg;

  localparam int DEF_PHASE_BITS = 14;
  localparam int DEF_OUT_BITS   = 12;

  localparam logic [47:0] GAIN_48 = 48'h26DD3B6A10D8;

  localparam logic [47:0] ATAN48 [32] = '{
    48'h200000000000, 48'h12E4051D9DF3, 48'h09FB385B5EE4, 48'h051111D41DDE,
    48'h028B0D430E59, 48'h0145D7E15904, 48'h00A2F61E5C28, 48'h00517C5511D4,
    48'h0028BE5346D1, 48'h00145F2EBB31, 48'h000A2F980092, 48'h000517CC14A8,
    48'h00028BE60CE0, 48'h000145F306C1, 48'h0000A2F9836B, 48'h0000517CC1B7,
    48'h000028BE60DC, 48'h0000145F306E, 48'h00000A2F9837, 48'h00000517CC1B,
    48'h0000028BE60E, 48'h00000145F307, 48'h000000A2F983, 48'h000000517CC2,
    48'h00000028BE61, 48'h000000145F30, 48'h0000000A2F98, 48'h0000000517CC,
    48'h000000028BE6, 48'h0000000145F3, 48'h00000000A2FA, 48'h00000000517D
  };

  // arctangent of step k at out_bits resolution; last step rotates by zero
  function automatic logic [47:0] atan_at(input int k, input int out_bits);
    logic [47:0] res;
    res = '0;
    if (k + 1 < out_bits) begin
      res = ATAN48[k] >> (47 - out_bits);
    end
    return res;
  endfunction

  function automatic logic [47:0] gain_at(input int out_bits);
    return GAIN_48 >> (46 - out_bits);
  endfunction

endpackage

### rtl/csc_if.sv
interface csc_in_if #(
  parameter int PHASE_BITS = csc_pkg::DEF_PHASE_BITS
);
  logic                  valid;
  logic                  ready;
  logic [PHASE_BITS-1:0] phase;

  modport source (output valid, output phase, input ready);
  modport sink (input valid, input phase, output ready);
endinterface

interface csc_out_if #(
  parameter int OUT_BITS = csc_pkg::DEF_OUT_BITS
);
  logic                       valid;
  logic                       ready;
  logic signed [OUT_BITS-1:0] sine;
  logic signed [OUT_BITS-1:0] cosine;

  modport source (output valid, output sine, output cosine, input ready);
  modport sink (input valid, input sine, input cosine, output ready);
endinterface

### rtl/csc_stage.sv
module csc_stage #(
  parameter int W  = csc_pkg::DEF_OUT_BITS + 2,
  parameter int K  = 0,
  parameter int OB = csc_pkg::DEF_OUT_BITS
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                up_valid,
  output logic                up_ready,
  input  logic signed [W-1:0] x_in,
  input  logic signed [W-1:0] y_in,
  input  logic signed [W-1:0] z_in,
  input  logic [1:0]          quad_in,
  output logic                dn_valid,
  input  logic                dn_ready,
  output logic signed [W-1:0] x_out,
  output logic signed [W-1:0] y_out,
  output logic signed [W-1:0] z_out,
  output logic [1:0]          quad_out
);

  typedef logic signed [W-1:0] word_t;

  localparam word_t ANG = word_t'(csc_pkg::atan_at(K, OB));

  logic  valid_r, valid_nxt;
  word_t x_r, y_r, z_r;
  word_t x_nxt, y_nxt, z_nxt;
  word_t x_sh, y_sh;
  logic [1:0] quad_r;

  assign up_ready  = !valid_r || dn_ready;
  assign valid_nxt = up_ready ? up_valid : valid_r;

  assign x_sh = x_in >>> K;
  assign y_sh = y_in >>> K;

  always_comb begin
    if (z_in[W-1]) begin
      x_nxt = x_in + y_sh;
      y_nxt = y_in - x_sh;
      z_nxt = z_in + ANG;
    end else begin
      x_nxt = x_in - y_sh;
      y_nxt = y_in + x_sh;
      z_nxt = z_in - ANG;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (up_valid && up_ready) begin
      x_r    <= x_nxt;
      y_r    <= y_nxt;
      z_r    <= z_nxt;
      quad_r <= quad_in;
    end
  end

  assign dn_valid = valid_r;
  assign x_out    = x_r;
  assign y_out    = y_r;
  assign z_out    = z_r;
  assign quad_out = quad_r;

endmodule

### rtl/cordic_sine_cosine_top.sv
// Registers from input item to result item, in order:
// one input register, one CORDIC rotation stage per step, one output register.
// Throughput: one item per cycle; each stage holds its item while the next is full.
// Reset: synchronous, active low; clears all stage valid bits, payload is not reset.
module cordic_sine_cosine_top #(
  parameter int PHASE_BITS = csc_pkg::DEF_PHASE_BITS,
  parameter int OUT_BITS   = csc_pkg::DEF_OUT_BITS
) (
  input logic        clk,
  input logic        rst_n,
  csc_in_if.sink     in_ch,
  csc_out_if.source  out_ch
);

  localparam int W  = OUT_BITS + 2;
  localparam int TB = PHASE_BITS - 2;

  typedef logic signed [W-1:0] word_t;
  typedef enum logic [1:0] {QUAD_I, QUAD_II, QUAD_III, QUAD_IV} quad_t;

  localparam word_t X0 = word_t'(csc_pkg::gain_at(OUT_BITS));

  logic [TB-1:0] resid;
  word_t         z_in;

  logic          v0_r, v0_nxt;
  word_t         z0_r;
  logic [1:0]    q0_r;

  logic          vld  [0:OUT_BITS];
  logic          rdy  [1:OUT_BITS+1];
  word_t         xs   [0:OUT_BITS];
  word_t         ys   [0:OUT_BITS];
  word_t         zs   [0:OUT_BITS];
  logic [1:0]    qs   [0:OUT_BITS];

  word_t                      c_sh, s_sh;
  logic [OUT_BITS-1:0]        c_w, s_w;
  logic [OUT_BITS-1:0]        sine_nxt, cosine_nxt;
  logic signed [OUT_BITS-1:0] sine_r, cosine_r;
  logic                       out_valid_r, out_valid_nxt;
  logic                       last_ready;

  assign resid = in_ch.phase[TB-1:0];

  generate
    if (PHASE_BITS - 1 < OUT_BITS) begin : g_up
      assign z_in = word_t'(resid) << (OUT_BITS - PHASE_BITS + 1);
    end else begin : g_down
      assign z_in = word_t'(resid >> (PHASE_BITS - OUT_BITS)) << 1;
    end
  endgenerate

  // input register
  assign in_ch.ready = !v0_r || rdy[1];
  assign v0_nxt      = in_ch.ready ? in_ch.valid : v0_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
    end else begin
      v0_r <= v0_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      z0_r <= z_in;
      q0_r <= in_ch.phase[PHASE_BITS-1 -: 2];
    end
  end

  assign vld[0] = v0_r;
  assign xs[0]  = X0;
  assign ys[0]  = '0;
  assign zs[0]  = z0_r;
  assign qs[0]  = q0_r;

  // rotation stages
  generate
    for (genvar i = 1; i <= OUT_BITS; i++) begin : g_stage
      csc_stage #(
        .W  (W),
        .K  (i - 1),
        .OB (OUT_BITS)
      ) u_stage (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (vld[i-1]),
        .up_ready (rdy[i]),
        .x_in     (xs[i-1]),
        .y_in     (ys[i-1]),
        .z_in     (zs[i-1]),
        .quad_in  (qs[i-1]),
        .dn_valid (vld[i]),
        .dn_ready (rdy[i+1]),
        .x_out    (xs[i]),
        .y_out    (ys[i]),
        .z_out    (zs[i]),
        .quad_out (qs[i])
      );
    end
  endgenerate

  // quadrant fold and output register
  assign c_sh = xs[OUT_BITS] >>> 2;
  assign s_sh = ys[OUT_BITS] >>> 2;
  assign c_w  = c_sh[OUT_BITS-1:0];
  assign s_w  = s_sh[OUT_BITS-1:0];

  always_comb begin
    case (quad_t'(qs[OUT_BITS]))
      QUAD_I: begin
        sine_nxt   = s_w;
        cosine_nxt = c_w;
      end
      QUAD_II: begin
        sine_nxt   = c_w;
        cosine_nxt = ~s_w;
      end
      QUAD_III: begin
        sine_nxt   = ~s_w;
        cosine_nxt = ~c_w;
      end
      QUAD_IV: begin
        sine_nxt   = ~c_w;
        cosine_nxt = s_w;
      end
      default: begin
        sine_nxt   = s_w;
        cosine_nxt = c_w;
      end
    endcase
  end

  assign last_ready       = !out_valid_r || out_ch.ready;
  assign rdy[OUT_BITS+1]  = last_ready;
  assign out_valid_nxt    = last_ready ? vld[OUT_BITS] : out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (vld[OUT_BITS] && last_ready) begin
      sine_r   <= $signed(sine_nxt);
      cosine_r <= $signed(cosine_nxt);
    end
  end

  assign out_ch.valid  = out_valid_r;
  assign out_ch.sine   = sine_r;
  assign out_ch.cosine = cosine_r;

endmodule

### rtl/csc_chk.sv
module csc_chk #(
  parameter int OUT_BITS = csc_pkg::DEF_OUT_BITS
) (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_ready,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic signed [OUT_BITS-1:0] sine,
  input logic signed [OUT_BITS-1:0] cosine
);

  localparam int LIM = 2 ** (OUT_BITS - 2) + 2 ** (OUT_BITS - 3);

  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  a_ready_chain: assert property (@(posedge clk) disable iff (!rst_n)
    out_ready |-> in_ready)
    else $error("input stalled while result side is ready");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(sine) && $stable(cosine))
    else $error("stalled result item changed");

  a_amplitude: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (sine <= LIM) && (sine >= -LIM) && (cosine <= LIM) && (cosine >= -LIM))
    else $error("result amplitude out of range");

endmodule

bind cordic_sine_cosine_top csc_chk #(
  .OUT_BITS (OUT_BITS)
) u_csc_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .sine      (out_ch.sine),
  .cosine    (out_ch.cosine)
);

### test/cordic_sine_cosine_top_tb.sv
`timescale 1ns / 100ps

module cordic_sine_cosine_top_tb;

  localparam int PB = csc_pkg::DEF_PHASE_BITS;
  localparam int OB = csc_pkg::DEF_OUT_BITS;
  localparam int LATENCY = OB + 2;
  localparam int N_RANDOM = 1800;
  localparam int N_ROWS = 20;
  localparam int HOLD_CYCLES = 300;

  typedef struct packed {
    logic signed [OB-1:0] sine;
    logic signed [OB-1:0] cosine;
  } wave_t;

  typedef struct packed {
    logic [PB-1:0] phase;
    bit            typed;
    wave_t         want;
  } row_t;

  logic clk;
  logic rst_n;

  csc_in_if #(.PHASE_BITS(PB)) in_ch ();
  csc_out_if #(.OUT_BITS(OB)) out_ch ();

  cordic_sine_cosine_top #(
    .PHASE_BITS(PB),
    .OUT_BITS  (OB)
  ) dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch.sink),
    .out_ch(out_ch.source)
  );

  wave_t expected_waves[$];
  int    n_fail;
  int    tx_idle_pct;
  int    rx_idle_pct;
  bit    hold_req;
  bit    item_typed;
  wave_t item_want;
  row_t  directed_rows [N_ROWS];

  function automatic wave_t sincos_of(input logic [PB-1:0] ph);
    wave_t       res;
    logic [1:0]  quad;
    longint      t;
    longint      x;
    longint      y;
    longint      z;
    longint      xs;
    longint      ys;
    longint      ang;
    longint      c;
    longint      s;
    longint      rs;
    longint      rc;
    int          sh;
    quad = ph[PB-1 -: 2];
    t = longint'(ph[PB-3:0]);
    if (PB - 1 < OB) begin
      sh = OB - PB + 1;
      z = t << sh;
    end else begin
      sh = PB - OB;
      z = (t >> sh) << 1;
    end
    x = longint'(csc_pkg::GAIN_48 >> (48 - OB - 2));
    y = 0;
    for (int k = 0; k < OB; k++) begin
      xs = x >>> k;
      ys = y >>> k;
      ang = 0;
      if (k + 1 < OB) begin
        ang = longint'(csc_pkg::ATAN48[k] >> (48 - OB - 1));
      end
      if (z < 0) begin
        x = x + ys;
        y = y - xs;
        z = z + ang;
      end else begin
        x = x - ys;
        y = y + xs;
        z = z - ang;
      end
    end
    c = x >>> 2;
    s = y >>> 2;
    case (quad)
      2'd0: begin
        rs = s;
        rc = c;
      end
      2'd1: begin
        rs = c;
        rc = ~s;
      end
      2'd2: begin
        rs = ~s;
        rc = ~c;
      end
      default: begin
        rs = ~c;
        rc = s;
      end
    endcase
    res.sine = rs[OB-1:0];
    res.cosine = rc[OB-1:0];
    return res;
  endfunction

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    wave_t want;
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) begin
        expected_waves.push_back(item_typed ? item_want : sincos_of(in_ch.phase));
      end
      if (out_ch.valid && out_ch.ready) begin
        if (expected_waves.size() == 0) begin
          n_fail++;
          $display("%0t: unexpected item, expected none, actual sine %0d cosine %0d",
                   $time, out_ch.sine, out_ch.cosine);
        end else begin
          want = expected_waves.pop_front();
          if (out_ch.sine !== want.sine) begin
            n_fail++;
            $display("%0t: sine mismatch, expected %0d, actual %0d",
                     $time, want.sine, out_ch.sine);
          end
          if (out_ch.cosine !== want.cosine) begin
            n_fail++;
            $display("%0t: cosine mismatch, expected %0d, actual %0d",
                     $time, want.cosine, out_ch.cosine);
          end
        end
      end
    end
  end

  initial begin
    bit held;
    held = 1'b0;
    out_ch.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_req && !held) begin
        held = 1'b1;
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      out_ch.ready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end
  end

  task automatic send_phase(input logic [PB-1:0] ph, input bit typed, input wave_t want);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.phase <= ph;
    item_typed <= typed;
    item_want <= want;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  initial begin
    #2_000_000;
    $display("cordic_sine_cosine_top verification failed");
    $finish;
  end

  initial begin
    clk = 1'b0;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.phase = '0;
    item_typed = 1'b0;
    item_want = '0;
    n_fail = 0;
    tx_idle_pct = 33;
    rx_idle_pct = 33;
    hold_req = 1'b0;

    directed_rows = '{
      '{14'h0000, 1'b1, '{12'sd0, 12'sd1024}},
      '{14'h0003, 1'b1, '{12'sd0, 12'sd1024}},
      '{14'h1000, 1'b1, '{12'sd1024, -12'sd1}},
      '{14'h2000, 1'b1, '{-12'sd1, -12'sd1025}},
      '{14'h3000, 1'b1, '{-12'sd1025, 12'sd0}},
      '{14'h0001, 1'b0, '0},
      '{14'h0004, 1'b0, '0},
      '{14'h0400, 1'b0, '0},
      '{14'h0800, 1'b0, '0},
      '{14'h0C00, 1'b0, '0},
      '{14'h0FFF, 1'b0, '0},
      '{14'h1555, 1'b0, '0},
      '{14'h1800, 1'b0, '0},
      '{14'h1FFF, 1'b0, '0},
      '{14'h2800, 1'b0, '0},
      '{14'h2AAA, 1'b0, '0},
      '{14'h2FFF, 1'b0, '0},
      '{14'h3800, 1'b0, '0},
      '{14'h3FFC, 1'b0, '0},
      '{14'h3FFF, 1'b0, '0}
    };

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (directed_rows[i]) begin
      send_phase(directed_rows[i].phase, directed_rows[i].typed, directed_rows[i].want);
    end

    tx_idle_pct = 0;
    rx_idle_pct = 0;
    for (int i = 0; i < N_RANDOM; i++) begin
      if (i == 400) begin
        tx_idle_pct = 33;
        rx_idle_pct = 33;
      end
      if (i == 600) begin
        hold_req = 1'b1;
      end
      if (i == 1100) begin
        in_ch.valid <= 1'b0;
        @(negedge clk);
        while (expected_waves.size() != 0) @(negedge clk);
      end
      send_phase(PB'($urandom_range(0, (1 << PB) - 1)), 1'b0, '0);
    end
    in_ch.valid <= 1'b0;

    while (expected_waves.size() != 0) @(posedge clk);
    repeat (3 * LATENCY) @(posedge clk);

    if (n_fail == 0) begin
      $display("cordic_sine_cosine_top verification clean");
    end else begin
      $display("cordic_sine_cosine_top verification failed");
    end
    $finish;
  end

endmodule
